>>> hdl/xbm_pkg.sv
// ----------------------------------------------------------------------------
// xbm_pkg: shared types and constants of the xorshift byte mutator
// Holds the generator step, register indexes, action codes and the
// transaction types passed between the mutator modules.
// ----------------------------------------------------------------------------
package xbm_pkg;

  // Generator and register constants
  localparam logic [31:0] SeedDefault   = 32'h1BAD_CAFE;
  localparam logic [15:0] MaxLenReset   = 16'hFFFF;
  localparam logic [15:0] CountSat      = 16'hFFFF;
  localparam int unsigned CfgIdxW       = 8;
  localparam int unsigned CfgDataW      = 32;

  // Result queue geometry
  localparam int unsigned QDepth        = 4;
  localparam int unsigned QCntW         = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPrngSeed  = 8'd0,
    CfgMaxLength = 8'd1
  } cfg_idx_e;

  // Mutation actions selected by the low nibble of a draw
  typedef enum logic [3:0] {
    ActReplace = 4'd0,
    ActFlip    = 4'd1,
    ActClear   = 4'd2,
    ActSet     = 4'd3,
    ActSwap    = 4'd4
  } act_e;

  // One input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_appended;
  } result_t;

  // Configuration write seen by the core
  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // Results released by one step, packed from entry 0 upward
  typedef struct packed {
    logic [1:0]        cnt;
    result_t [1:0]     item;
  } push_t;

  // One xorshift32 step (shifts 13, 17, 5)
  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

>>> hdl/xbm_in_if.sv
// ----------------------------------------------------------------------------
// xbm_in_if: input byte channel
// Valid/ready channel carrying one buffer byte and its last marker.
// ----------------------------------------------------------------------------
interface xbm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> hdl/xbm_out_if.sv
// ----------------------------------------------------------------------------
// xbm_out_if: result byte channel
// Valid/ready channel carrying one mutated byte with its flags.
// ----------------------------------------------------------------------------
interface xbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_appended;

  modport source (output valid, output out_byte, output out_last, output out_appended,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input out_appended,
                  output ready);
endinterface

>>> hdl/xbm_cfg_if.sv
// ----------------------------------------------------------------------------
// xbm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface xbm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [xbm_pkg::CfgIdxW-1:0]  index;
  logic [xbm_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/xorshift_byte_mutator.sv
// ----------------------------------------------------------------------------
// xorshift_byte_mutator: streaming byte mutator
// Top level: input register, mutation core and result queue.
// ----------------------------------------------------------------------------
// The block accepts one byte per cycle while the result queue has room; the
// byte waits in the input register, its results in the result queue. The
// xorshift32 generator advances once per byte through up to four chained
// steps in a single cycle. Results leave at one per cycle while the output
// is ready, and the input pauses once the result queue fills. A step never
// releases more than two results: a third (an appended byte after a last
// byte that completes a swap, or one behind a released spill) is held inside
// and sent only once the next byte has been accepted, ahead of that byte's
// results. Configuration writes are always ready and must be issued while
// the block is idle; writing the seed reloads the generator (zero loads
// 0x1BADCAFE). There is no clearing pass.
module xorshift_byte_mutator (
  input  logic   clk_i,
  input  logic   rst_ni,
  xbm_in_if.sink    in_i,
  xbm_out_if.source out_o,
  xbm_cfg_if.sink   cfg_i
);

  xbm_pkg::in_item_t in_q;
  logic              in_v_q;
  logic              step;
  logic              space;
  xbm_pkg::cfg_wr_t  cfg_wr;
  xbm_pkg::push_t    push;
  xbm_pkg::result_t  head;

  // Process the registered byte when the queue has room
  assign step       = in_v_q && space;
  assign in_i.ready = !in_v_q || step;
  assign cfg_i.ready = 1'b1;

  // Hand the configuration transaction to the core
  assign cfg_wr.valid = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  // Hold the input valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_v_q <= 1'b1;
    end else if (step) begin
      in_v_q <= 1'b0;
    end
  end

  // Capture the input payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.in_byte <= in_i.in_byte;
      in_q.in_last <= in_i.in_last;
    end
  end

  xbm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg_wr),
    .push_o (push)
  );

  xbm_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .head_o  (head),
    .valid_o (out_o.valid),
    .space_o (space)
  );

  assign out_o.out_byte     = head.out_byte;
  assign out_o.out_last     = head.out_last;
  assign out_o.out_appended = head.out_appended;

  // A registered byte waits until it is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !step) |=> in_v_q)
    else $error("input byte dropped before processing");

endmodule

>>> hdl/xbm_core.sv
// ----------------------------------------------------------------------------
// xbm_core: mutation step and buffer state
// Draws up to four chained xorshift32 values per byte, applies the selected
// action, tracks swap, byte count and spill state, and releases the results.
// ----------------------------------------------------------------------------
module xbm_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  xbm_pkg::in_item_t item_i,
  input  xbm_pkg::cfg_wr_t  cfg_i,
  output xbm_pkg::push_t    push_o
);

  // State
  logic [31:0]      prng_q, prng_d;
  logic [7:0]       carried_q, carried_d;
  logic             swap_q, swap_d;
  logic [15:0]      count_q, count_d;
  logic [15:0]      max_len_q, max_len_d;
  logic             spill_v_q, spill_v_d;
  xbm_pkg::result_t spill_q, spill_d;

  // Step values
  logic [31:0]      x1, x2, x3, x4;
  logic [15:0]      count_inc;
  logic [7:0]       base_byte;
  logic [7:0]       cur;
  logic             replace;
  logic             hold;
  logic [31:0]      r2;
  logic [31:0]      app_src;
  logic             appended;
  logic [31:0]      prng_next;
  xbm_pkg::result_t res_a, res_cur, res_app;
  xbm_pkg::result_t n0, n1, n2;
  logic             v0, v1, v2;

  // Chain the draws
  assign x1 = xbm_pkg::xorshift32(prng_q);
  assign x2 = xbm_pkg::xorshift32(x1);
  assign x3 = xbm_pkg::xorshift32(x2);
  assign x4 = xbm_pkg::xorshift32(x3);

  // Count the byte, saturating
  assign count_inc = (count_q == xbm_pkg::CountSat) ? count_q : count_q + 16'd1;

  // Take the carried byte after a swap
  assign base_byte = swap_q ? carried_q : item_i.in_byte;

  // Apply the action of the first draw
  always_comb begin
    cur     = base_byte;
    replace = 1'b0;
    hold    = 1'b0;
    case (xbm_pkg::act_e'(x1[3:0]))
      xbm_pkg::ActReplace: begin
        cur     = x2[7:0];
        replace = 1'b1;
      end
      xbm_pkg::ActFlip:  cur = base_byte ^ (8'd1 << x1[8:6]);
      xbm_pkg::ActClear: cur = 8'h00;
      xbm_pkg::ActSet:   cur = 8'hFF;
      xbm_pkg::ActSwap:  hold = !item_i.in_last;
      default: ;
    endcase
  end

  // Decide the append after a last byte and pick the final generator value
  assign r2       = replace ? x3 : x2;
  assign app_src  = replace ? x4 : x3;
  assign appended = item_i.in_last && r2[0] && (count_inc < max_len_q);

  always_comb begin
    if (!item_i.in_last) begin
      prng_next = replace ? x2 : x1;
    end else if (appended) begin
      prng_next = app_src;
    end else begin
      prng_next = r2;
    end
  end

  // Form the candidate results
  assign res_a   = '{out_byte: item_i.in_byte, out_last: 1'b0, out_appended: 1'b0};
  assign res_cur = '{out_byte: cur, out_last: item_i.in_last && !appended,
                     out_appended: 1'b0};
  assign res_app = '{out_byte: app_src[7:0], out_last: 1'b1, out_appended: 1'b1};

  // Pack the new results in order: swapped-in byte, current byte, appended byte
  assign n0 = swap_q ? res_a : res_cur;
  assign v0 = swap_q || !hold;
  assign n1 = swap_q ? res_cur : res_app;
  assign v1 = swap_q ? !hold : appended;
  assign n2 = res_app;
  assign v2 = swap_q && !hold && appended;

  // Release an old spill first; a result beyond two waits in the spill
  always_comb begin
    push_o = '0;
    if (step_i) begin
      if (spill_v_q) begin
        push_o.item[0] = spill_q;
        push_o.item[1] = n0;
        push_o.cnt     = 2'd1 + 2'(v0);
      end else begin
        push_o.item[0] = n0;
        push_o.item[1] = n1;
        push_o.cnt     = 2'(v0) + 2'(v1);
      end
    end
  end

  // Advance state on a step, load registers on a configuration write
  always_comb begin
    prng_d    = prng_q;
    carried_d = carried_q;
    swap_d    = swap_q;
    count_d   = count_q;
    max_len_d = max_len_q;
    spill_v_d = spill_v_q;
    spill_d   = spill_q;
    if (step_i) begin
      prng_d    = prng_next;
      swap_d    = hold;
      count_d   = item_i.in_last ? 16'd0 : count_inc;
      spill_v_d = spill_v_q ? v1 : v2;
      spill_d   = spill_v_q ? n1 : n2;
      if (hold) begin
        carried_d = cur;
      end
    end
    if (cfg_i.valid) begin
      case (xbm_pkg::cfg_idx_e'(cfg_i.index))
        xbm_pkg::CfgPrngSeed: begin
          prng_d = (cfg_i.data == '0) ? xbm_pkg::SeedDefault : cfg_i.data;
        end
        xbm_pkg::CfgMaxLength: max_len_d = cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prng_q    <= xbm_pkg::SeedDefault;
      swap_q    <= 1'b0;
      count_q   <= 16'd0;
      max_len_q <= xbm_pkg::MaxLenReset;
      spill_v_q <= 1'b0;
    end else begin
      prng_q    <= prng_d;
      swap_q    <= swap_d;
      count_q   <= count_d;
      max_len_q <= max_len_d;
      spill_v_q <= spill_v_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    carried_q <= carried_d;
    spill_q   <= spill_d;
  end

  // A spill comes only from a last byte, so no swap is open beside it
  assert property (@(posedge clk_i) disable iff (!rst_ni) spill_v_q |-> !swap_q)
    else $error("spill held while a swap is pending");

  // Only a last byte can leave a spill behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !item_i.in_last) |=> !spill_v_q)
    else $error("spill produced by a byte that is not last");

endmodule

>>> hdl/xbm_out_queue.sv
// ----------------------------------------------------------------------------
// xbm_out_queue: result queue
// Shifting four-entry queue that takes up to two results per cycle and
// presents one result per cycle at its head.
// ----------------------------------------------------------------------------
module xbm_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  xbm_pkg::push_t   push_i,
  input  logic             pop_i,
  output xbm_pkg::result_t head_o,
  output logic             valid_o,
  output logic             space_o
);

  localparam int unsigned Depth = xbm_pkg::QDepth;

  xbm_pkg::result_t          q_q     [Depth];
  xbm_pkg::result_t          q_d     [Depth];
  xbm_pkg::result_t          shifted [Depth];
  logic [xbm_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic [xbm_pkg::QCntW-1:0] keep;
  logic [xbm_pkg::QCntW-1:0] src_new [Depth];
  logic                      pop;

  assign pop     = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  assign head_o  = q_q[0];
  // Room for a full step of two results
  assign space_o = (cnt_q <= xbm_pkg::QCntW'(Depth - 2));
  assign keep    = cnt_q - xbm_pkg::QCntW'(pop);
  assign cnt_d   = keep + xbm_pkg::QCntW'(push_i.cnt);

  // Shift out the head, then append pushed results behind the kept ones
  always_comb begin
    shifted[Depth-1] = q_q[Depth-1];
    for (int i = 0; i < Depth - 1; i++) begin
      shifted[i] = pop ? q_q[i+1] : q_q[i];
    end
    for (int i = 0; i < Depth; i++) begin
      src_new[i] = xbm_pkg::QCntW'(i) - keep;
      if (xbm_pkg::QCntW'(i) < keep) begin
        q_d[i] = shifted[i];
      end else if (src_new[i] < xbm_pkg::QCntW'(push_i.cnt)) begin
        q_d[i] = push_i.item[src_new[i][0]];
      end else begin
        q_d[i] = q_q[i];
      end
    end
  end

  // Hold the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the entries
  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= xbm_pkg::QCntW'(Depth))
    else $error("result queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> space_o)
    else $error("results pushed without room");

endmodule

>>> tb/xorshift_byte_mutator_tb.sv
// ----------------------------------------------------------------------------
// xorshift_byte_mutator_tb: self-checking bench for the byte mutator
// Streams byte buffers through the mutator with random gaps on both sides,
// predicts every mutated, swapped and appended byte from an xorshift32
// generator kept in step with the block, and compares each output
// transaction field by field. Seed and capacity are reprogrammed between
// phases, including zero seed and zero and unit capacity.
// ----------------------------------------------------------------------------

class mutated_stream_tracker;
  logic [31:0] gen_state;
  logic [15:0] max_len;
  logic [15:0] buf_count;
  logic [7:0]  held_byte;
  bit          swap_armed;
  bit          spill_waiting;
  int          mismatches;
  xbm_pkg::result_t pending_bytes[$];

  function new();
    gen_state     = xbm_pkg::SeedDefault;
    max_len       = xbm_pkg::MaxLenReset;
    buf_count     = '0;
    held_byte     = '0;
    swap_armed    = 0;
    spill_waiting = 0;
    mismatches    = 0;
  endfunction

  function void report(string what);
    mismatches++;
    $display("mismatch: %s", what);
  endfunction

  // Advance the generator one xorshift32 step
  function logic [31:0] advance_gen();
    logic [31:0] x;
    x = gen_state;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    gen_state = x;
    return x;
  endfunction

  function void push_byte(logic [7:0] b, logic l, logic a);
    xbm_pkg::result_t r;
    r.out_byte     = b;
    r.out_last     = l;
    r.out_appended = a;
    pending_bytes.push_back(r);
  endfunction

  function void load_reg(logic [7:0] idx, logic [31:0] data);
    case (xbm_pkg::cfg_idx_e'(idx))
      xbm_pkg::CfgPrngSeed:  gen_state = (data != '0) ? data : xbm_pkg::SeedDefault;
      xbm_pkg::CfgMaxLength: max_len = data[15:0];
      default: ;
    endcase
  endfunction

  // Predict the outputs caused by one accepted input transaction
  function void take_byte(logic [7:0] b, logic last);
    logic [31:0] r;
    logic [31:0] r2;
    logic [31:0] extra;
    logic [7:0]  cur;
    logic [7:0]  app_byte;
    bit          hold;
    bit          app;
    int          n;
    hold     = 0;
    app      = 0;
    app_byte = '0;
    // a withheld third byte from the previous step goes out first
    n = spill_waiting ? 1 : 0;
    spill_waiting = 0;
    if (buf_count != xbm_pkg::CountSat) buf_count++;
    // complete a pending swap: the new byte passes through unchanged
    if (swap_armed) begin
      push_byte(b, 1'b0, 1'b0);
      n++;
      cur = held_byte;
      swap_armed = 0;
    end else begin
      cur = b;
    end
    r = advance_gen();
    case (xbm_pkg::act_e'(r[3:0]))
      xbm_pkg::ActReplace: begin
        extra = advance_gen();
        cur = extra[7:0];
      end
      xbm_pkg::ActFlip:  cur = cur ^ (8'd1 << r[8:6]);
      xbm_pkg::ActClear: cur = 8'h00;
      xbm_pkg::ActSet:   cur = 8'hFF;
      xbm_pkg::ActSwap: begin
        if (!last) begin
          held_byte  = cur;
          swap_armed = 1;
          hold       = 1;
        end
      end
      default: ;
    endcase
    // decide on an appended byte after the end of the buffer
    if (last) begin
      r2 = advance_gen();
      if (r2[0] && buf_count < max_len) begin
        extra    = advance_gen();
        app_byte = extra[7:0];
        app      = 1;
      end
    end
    if (!hold) begin
      push_byte(cur, last && !app, 1'b0);
      n++;
    end
    if (app) begin
      push_byte(app_byte, 1'b1, 1'b1);
      n++;
    end
    if (last) buf_count = '0;
    spill_waiting = (n > 2);
  endfunction

  // Compare one output transaction against the oldest expectation
  function void match_byte(logic [7:0] b, logic l, logic a);
    xbm_pkg::result_t e;
    if (pending_bytes.size() == 0) begin
      report($sformatf("unexpected byte %h last %b appended %b", b, l, a));
      return;
    end
    e = pending_bytes.pop_front();
    if (b !== e.out_byte)
      report($sformatf("out_byte %h, expected %h", b, e.out_byte));
    if (l !== e.out_last)
      report($sformatf("out_last %b, expected %b (byte %h)", l, e.out_last, e.out_byte));
    if (a !== e.out_appended)
      report($sformatf("out_appended %b, expected %b (byte %h)", a, e.out_appended,
                       e.out_byte));
  endfunction
endclass

module xorshift_byte_mutator_tb;

  localparam logic [xbm_pkg::CfgIdxW-1:0] CfgIdxSpare = 8'd9;
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 4;
  localparam int PhaseItems    = 120;

  logic clk_i;
  logic rst_ni;
  bit   burst_mode;
  int   idle_cycles;

  mutated_stream_tracker sb;

  xbm_in_if  in_if();
  xbm_out_if out_if();
  xbm_cfg_if cfg_if();

  xorshift_byte_mutator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Output sink: random stall before each transaction, then check it
  initial begin
    int w;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      w = burst_mode ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      sb.match_byte(out_if.out_byte, out_if.out_last, out_if.out_appended);
    end
  end

  // Send one input transaction after a random gap
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.take_byte(b, last);
  endtask

  task automatic send_buffer(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
  endtask

  // Flush any withheld byte or open swap, drain outputs, then let the block settle
  task automatic quiesce();
    while (sb.spill_waiting || sb.swap_armed) begin
      if (sb.spill_waiting) send_byte(8'($urandom), 1'b0);
      else                  send_byte(8'($urandom), 1'b1);
    end
    in_if.valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [xbm_pkg::CfgIdxW-1:0] idx,
                           input logic [xbm_pkg::CfgDataW-1:0] data);
    quiesce();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    sb.load_reg(idx, data);
  endtask

  // Stimulus
  initial begin
    logic [31:0] seed;
    logic [15:0] cap;
    int          sent;
    int          len;
    sb = new();
    burst_mode     = 0;
    rst_ni         = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    in_if.in_last <= 1'b0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.data   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, byte extremes, single-byte buffers
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    // zero seed loads the default, spare index is ignored
    write_reg(xbm_pkg::CfgPrngSeed, 32'h0);
    write_reg(CfgIdxSpare, 32'hDEAD_BEEF);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h0F, 1'b1);
    // zero capacity: never append
    write_reg(xbm_pkg::CfgMaxLength, 32'h0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);
    // unit capacity, then room for one append after a single byte
    write_reg(xbm_pkg::CfgMaxLength, 32'h1);
    send_byte(8'h33, 1'b1);
    send_byte(8'hF0, 1'b1);
    write_reg(xbm_pkg::CfgMaxLength, 32'h2);
    send_byte(8'h44, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    send_byte(8'hC3, 1'b1);

    // Random phases: new seed and capacity each time
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin seed = 32'hFFFF_FFFF; cap = 16'hFFFF; end
        1: begin seed = 32'h0000_0001; cap = 16'h0000; end
        2: begin seed = 32'h0;         cap = 16'h0001; end
        3: begin seed = $urandom;      cap = 16'h0002; end
        4: begin seed = $urandom;      cap = 16'($urandom_range(3, 12)); end
        default: begin seed = $urandom; cap = 16'($urandom_range(1, 65535)); end
      endcase
      write_reg(xbm_pkg::CfgPrngSeed, seed);
      write_reg(xbm_pkg::CfgMaxLength, {16'h0, cap});
      sent = 0;
      while (sent < PhaseItems) begin
        burst_mode = ($urandom_range(0, 5) == 0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        send_buffer(len);
        sent += len;
      end
      burst_mode = 0;
    end

    // A short closing buffer
    send_buffer(3);

    // Drain and finish
    quiesce();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
